### hw/rtl/gacm_pkg.sv
// shared types and codes of the crossover and mutation engine
package gacm_pkg;

    localparam int MAX_LENGTH = 64;
    localparam int IDX_W      = $clog2(MAX_LENGTH);
    localparam int LEN_W      = IDX_W + 1;
    localparam int DRAW_W     = 16;
    localparam int PROD_W     = DRAW_W + IDX_W;

    localparam logic OP_CROSS  = 1'b0;
    localparam logic OP_MUTATE = 1'b1;

    localparam logic [1:0] MODE_SINGLE  = 2'd0;
    localparam logic [1:0] MODE_MULTI   = 2'd1;
    localparam logic [1:0] MODE_UNIFORM = 2'd2;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_MASK_DIFF = 2'd1;
    localparam logic [1:0] ERR_VAL_DIFF  = 2'd2;

    localparam logic [2:0] CFG_LENGTH = 3'd0;
    localparam logic [2:0] CFG_MODE   = 3'd1;
    localparam logic [2:0] CFG_POINTS = 3'd2;
    localparam logic [2:0] CFG_RATE   = 3'd3;
    localparam logic [2:0] CFG_SEED   = 3'd4;

    typedef struct packed {
        logic [6:0]  length;
        logic [1:0]  mode;
        logic [5:0]  points;
        logic [16:0] rate;
    } cfg_t;

    typedef struct packed {
        logic [MAX_LENGTH-1:0] child_a;
        logic [MAX_LENGTH-1:0] child_b;
        logic [1:0]            error_code;
    } res_t;

endpackage

### hw/rtl/gacm_rng.sv
// xorshift32 random source, one draw per step
module gacm_rng (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        seed_wr,
    input  logic [31:0] seed,
    input  logic        step,
    output logic [gacm_pkg::DRAW_W-1:0] draw
);

    logic [31:0] state_reg;
    logic [31:0] state_next;
    logic [31:0] x1;
    logic [31:0] x2;
    logic [31:0] x3;

    always_comb begin
        x1 = state_reg ^ (state_reg << 13);
        x2 = x1 ^ (x1 >> 17);
        x3 = x2 ^ (x2 << 5);
        state_next = state_reg;
        if (seed_wr) begin
            state_next = (seed != 32'd0) ? seed : 32'd1;
        end else if (step) begin
            state_next = x3;
        end
    end

    assign draw = x3[31:32-gacm_pkg::DRAW_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= 32'd1;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/gacm_core.sv
// sequencer with one shared multiply and compare unit, one allele per cycle in the run state
module gacm_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  gacm_pkg::cfg_t       cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic [gacm_pkg::MAX_LENGTH-1:0] s_parent_a,
    input  logic [gacm_pkg::MAX_LENGTH-1:0] s_parent_b,
    input  logic [gacm_pkg::MAX_LENGTH-1:0] s_protect_a,
    input  logic [gacm_pkg::MAX_LENGTH-1:0] s_protect_b,
    input  logic [gacm_pkg::DRAW_W-1:0]     rng_draw,
    output logic                 rng_step,
    output logic                 res_valid,
    input  logic                 res_take,
    output gacm_pkg::res_t       res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_CUT   = 3'd3;
    localparam logic [2:0] ST_SPLIT = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    localparam int ML = gacm_pkg::MAX_LENGTH;
    localparam int IW = gacm_pkg::IDX_W;
    localparam int LW = gacm_pkg::LEN_W;
    localparam int PW = gacm_pkg::PROD_W;
    localparam int DW = gacm_pkg::DRAW_W;

    logic [2:0]     state_reg, state_next;
    logic           op_reg, op_next;
    logic [1:0]     mode_reg, mode_next;
    logic [LW-1:0]  len_reg, len_next;
    logic [IW-1:0]  k_reg, k_next;
    logic [IW-1:0]  chosen_reg, chosen_next;
    logic           swapped_reg, swapped_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [IW-1:0]  cut_reg, cut_next;
    logic [1:0]     err_reg, err_next;
    logic [ML-1:0]  pa_reg, pa_next;
    logic [ML-1:0]  pb_reg, pb_next;
    logic [ML-1:0]  qa_reg, qa_next;
    logic [ML-1:0]  qb_reg, qb_next;
    logic [ML-1:0]  sel_reg, sel_next;

    logic [LW-1:0]  len_c;
    logic [IW-1:0]  n_c;
    logic [IW-1:0]  k_c;
    logic [ML-1:0]  mask_c;
    logic [IW-1:0]  n_cur;
    logic [IW-1:0]  mult_op;
    logic [PW-1:0]  prod;
    logic [PW-1:0]  thresh;
    logic           hit;
    logic           heads;
    logic           below_rate;
    logic           last_pos;
    logic           swap_now;

    // clamp the configured length and point count
    always_comb begin
        if (cfg.length == 7'd0) begin
            len_c = LW'(1);
        end else if (LW'(cfg.length) > LW'(ML)) begin
            len_c = LW'(ML);
        end else begin
            len_c = LW'(cfg.length);
        end
        n_c = IW'(len_c - LW'(1));
        k_c = (cfg.points == 6'd0) ? IW'(1) : IW'(cfg.points);
        if (k_c > n_c) begin
            k_c = n_c;
        end
        for (int i = 0; i < ML; i++) begin
            mask_c[i] = LW'(i) < len_c;
        end
    end

    // shared multiply and compare unit
    assign n_cur      = IW'(len_reg - LW'(1));
    assign mult_op    = (mode_reg == gacm_pkg::MODE_MULTI) ? IW'(n_cur - idx_reg) : n_cur;
    assign prod       = PW'(rng_draw) * PW'(mult_op);
    assign thresh     = {IW'(k_reg - chosen_reg), DW'(0)};
    assign hit        = (chosen_reg < k_reg) && (prod < thresh);
    assign heads      = rng_draw > 16'h8000;
    assign below_rate = {1'b0, rng_draw} < cfg.rate;
    assign swap_now   = swapped_reg ^ hit;

    always_comb begin
        if (op_reg == gacm_pkg::OP_MUTATE || mode_reg != gacm_pkg::MODE_MULTI) begin
            last_pos = LW'(idx_reg) == LW'(len_reg - LW'(1));
        end else begin
            last_pos = LW'(idx_reg) == LW'(len_reg - LW'(2));
        end
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        mode_next    = mode_reg;
        len_next     = len_reg;
        k_next       = k_reg;
        chosen_next  = chosen_reg;
        swapped_next = swapped_reg;
        idx_next     = idx_reg;
        cut_next     = cut_reg;
        err_next     = err_reg;
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        qa_next      = qa_reg;
        qb_next      = qb_reg;
        sel_next     = sel_reg;
        rng_step     = 1'b0;
        s_ready      = 1'b0;
        res_valid    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next      = s_operation;
                    mode_next    = cfg.mode;
                    len_next     = len_c;
                    k_next       = k_c;
                    chosen_next  = '0;
                    swapped_next = 1'b0;
                    idx_next     = '0;
                    err_next     = gacm_pkg::ERR_OK;
                    pa_next      = s_parent_a & mask_c;
                    pb_next      = s_parent_b & mask_c;
                    qa_next      = s_protect_a & mask_c;
                    qb_next      = s_protect_b & mask_c;
                    sel_next     = '0;
                    state_next   = (s_operation == gacm_pkg::OP_MUTATE) ? ST_RUN : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (len_reg == LW'(1)) begin
                    rng_step = 1'b1;
                    if (!heads) begin
                        sel_next = ML'(1);
                    end
                    state_next = ST_DONE;
                end else if (qa_reg != qb_reg) begin
                    err_next   = gacm_pkg::ERR_MASK_DIFF;
                    state_next = ST_DONE;
                end else if (((pa_reg ^ pb_reg) & qa_reg) != '0) begin
                    err_next   = gacm_pkg::ERR_VAL_DIFF;
                    state_next = ST_DONE;
                end else begin
                    unique case (mode_reg)
                        gacm_pkg::MODE_SINGLE:  state_next = ST_CUT;
                        gacm_pkg::MODE_MULTI:   state_next = ST_RUN;
                        gacm_pkg::MODE_UNIFORM: state_next = ST_RUN;
                        default:                state_next = ST_DONE;
                    endcase
                end
            end
            ST_CUT: begin
                rng_step   = 1'b1;
                cut_next   = prod[PW-1:DW];
                state_next = ST_SPLIT;
            end
            ST_SPLIT: begin
                for (int i = 0; i < ML; i++) begin
                    sel_next[i] = (LW'(i) > LW'(cut_reg)) && (LW'(i) < len_reg);
                end
                state_next = ST_DONE;
            end
            ST_RUN: begin
                if (op_reg == gacm_pkg::OP_MUTATE) begin
                    if (!qa_reg[idx_reg]) begin
                        rng_step = 1'b1;
                        sel_next[idx_reg] = below_rate;
                    end
                end else if (mode_reg == gacm_pkg::MODE_MULTI) begin
                    rng_step     = 1'b1;
                    swapped_next = swap_now;
                    if (hit) begin
                        chosen_next = chosen_reg + IW'(1);
                    end
                    sel_next[IW'(idx_reg + IW'(1))] = swap_now;
                end else begin
                    rng_step = 1'b1;
                    sel_next[idx_reg] = !heads;
                end
                idx_next = idx_reg + IW'(1);
                if (last_pos) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (op_reg == gacm_pkg::OP_MUTATE) begin
            res.child_a = pa_reg ^ sel_reg;
            res.child_b = '0;
        end else if (err_reg != gacm_pkg::ERR_OK) begin
            res.child_a = '0;
            res.child_b = '0;
        end else begin
            res.child_a = (pa_reg & ~sel_reg) | (pb_reg & sel_reg);
            res.child_b = (pb_reg & ~sel_reg) | (pa_reg & sel_reg);
        end
        res.error_code = err_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        mode_reg    <= mode_next;
        len_reg     <= len_next;
        k_reg       <= k_next;
        chosen_reg  <= chosen_next;
        swapped_reg <= swapped_next;
        idx_reg     <= idx_next;
        cut_reg     <= cut_next;
        err_reg     <= err_next;
        pa_reg      <= pa_next;
        pb_reg      <= pb_next;
        qa_reg      <= qa_next;
        qb_reg      <= qb_next;
        sel_reg     <= sel_next;
    end

endmodule

### hw/rtl/ga_crossover_mutation_engine.sv
// top level: configuration registers, random source, sequencer and output register
//
// Usage
//   Input channel s_*: valid/ready; one item is a crossover (operation 0) or
//   mutate (operation 1) request with two chromosomes and their protection masks.
//   Result channel m_*: valid/ready; exactly one result item per input item.
//   Configuration: cfg_wr_en, cfg_index, cfg_wdata; write only while the block is
//   idle. Writing random_seed reloads the generator (zero loads one).
// Timing
//   In mutate, multi point and uniform modes the sequencer handles one allele
//   position per cycle on a shared multiplier and compare unit, drawing from the
//   generator as needed. Single point mode draws one cut and then splits. s_ready
//   returns the cycle after the result moves to the output register.
// Reset and stall
//   Reset restores the register defaults and a generator state of one.
//   A stalled result sits in the output register; the next item is still taken
//   and processed, and waits in the sequencer until the output register frees.
module ga_crossover_mutation_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [gacm_pkg::MAX_LENGTH-1:0] s_parent_a,
    input  logic [gacm_pkg::MAX_LENGTH-1:0] s_parent_b,
    input  logic [gacm_pkg::MAX_LENGTH-1:0] s_protect_a,
    input  logic [gacm_pkg::MAX_LENGTH-1:0] s_protect_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [gacm_pkg::MAX_LENGTH-1:0] m_child_a,
    output logic [gacm_pkg::MAX_LENGTH-1:0] m_child_b,
    output logic [1:0]  m_error_code
);

    gacm_pkg::cfg_t cfg_reg;
    gacm_pkg::res_t core_res;
    gacm_pkg::res_t out_reg;
    logic           m_valid_reg;
    logic           seed_wr;
    logic           rng_step;
    logic [gacm_pkg::DRAW_W-1:0] rng_draw;
    logic           res_valid;
    logic           res_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.length <= 7'd64;
            cfg_reg.mode   <= gacm_pkg::MODE_SINGLE;
            cfg_reg.points <= 6'd2;
            cfg_reg.rate   <= 17'd655;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gacm_pkg::CFG_LENGTH: cfg_reg.length <= cfg_wdata[6:0];
                gacm_pkg::CFG_MODE:   cfg_reg.mode   <= cfg_wdata[1:0];
                gacm_pkg::CFG_POINTS: cfg_reg.points <= cfg_wdata[5:0];
                gacm_pkg::CFG_RATE:   cfg_reg.rate   <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    assign seed_wr = cfg_wr_en && (cfg_index == gacm_pkg::CFG_SEED);

    gacm_rng u_rng (
        .aclk    (aclk),
        .aresetn (aresetn),
        .seed_wr (seed_wr),
        .seed    (cfg_wdata),
        .step    (rng_step),
        .draw    (rng_draw)
    );

    gacm_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_parent_a  (s_parent_a),
        .s_parent_b  (s_parent_b),
        .s_protect_a (s_protect_a),
        .s_protect_b (s_protect_b),
        .rng_draw    (rng_draw),
        .rng_step    (rng_step),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (core_res)
    );

    assign res_take = res_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            out_reg <= core_res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_child_a    = out_reg.child_a;
    assign m_child_b    = out_reg.child_b;
    assign m_error_code = out_reg.error_code;

endmodule

### verif/ga_crossover_mutation_engine_test.sv
// testbench for the crossover and mutation engine: directed and random requests against a predictor
`timescale 1ns / 1ps

module ga_crossover_mutation_engine_test;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 70;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_operation;
    logic [63:0] s_parent_a;
    logic [63:0] s_parent_b;
    logic [63:0] s_protect_a;
    logic [63:0] s_protect_b;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_child_a;
    logic [63:0] m_child_b;
    logic [1:0]  m_error_code;

    // predictor copy of the registers and generator
    logic [6:0]  len_reg;
    logic [1:0]  mode_reg;
    logic [5:0]  points_reg;
    logic [16:0] rate_reg;
    logic [31:0] xs_state;

    gacm_pkg::res_t pending_children[$];
    int   fault_count;
    int   stall_count;
    int   src_idle_pct;
    int   sink_stall_pct;

    ga_crossover_mutation_engine DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_parent_a   (s_parent_a),
        .s_parent_b   (s_parent_b),
        .s_protect_a  (s_protect_a),
        .s_protect_b  (s_protect_b),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_child_a    (m_child_a),
        .m_child_b    (m_child_b),
        .m_error_code (m_error_code)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] low_mask(input int unsigned n);
        if (n >= 64)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic int unsigned active_length();
        if (len_reg == 0)
            return 1;
        if (len_reg > gacm_pkg::MAX_LENGTH)
            return gacm_pkg::MAX_LENGTH;
        return 32'(len_reg);
    endfunction

    function automatic logic [15:0] next_draw();
        xs_state = xs_state ^ (xs_state << 13);
        xs_state = xs_state ^ (xs_state >> 17);
        xs_state = xs_state ^ (xs_state << 5);
        return xs_state[31:16];
    endfunction

    function automatic logic heads();
        return next_draw() > 16'd32768;
    endfunction

    function automatic gacm_pkg::res_t breed_result(input logic op, input logic [63:0] pa_in,
                                          input logic [63:0] pb_in, input logic [63:0] qa_in,
                                          input logic [63:0] qb_in);
        int unsigned len, n, k, chosen, c;
        logic [63:0] m, pa, pb, qa, qb, sel, ca;
        logic [15:0] d;
        logic        swapped;
        gacm_pkg::res_t r;
        len = active_length();
        m   = low_mask(len);
        pa  = pa_in & m;
        pb  = pb_in & m;
        qa  = qa_in & m;
        qb  = qb_in & m;
        r   = '0;
        sel = '0;
        if (op == gacm_pkg::OP_MUTATE) begin
            ca = pa;
            for (int i = 0; i < len; i++) begin
                if (!qa[i]) begin
                    d = next_draw();
                    if (d < rate_reg)
                        ca[i] = ~ca[i];
                end
            end
            r.child_a = ca;
            return r;
        end
        if (len == 1) begin
            if (!heads())
                sel = m;
        end else if (qa != qb) begin
            r.error_code = gacm_pkg::ERR_MASK_DIFF;
        end else if (((pa ^ pb) & qa) != 0) begin
            r.error_code = gacm_pkg::ERR_VAL_DIFF;
        end else begin
            case (mode_reg)
                gacm_pkg::MODE_SINGLE: begin
                    d   = next_draw();
                    c   = (d * (len - 1)) >> 16;
                    sel = m & ~low_mask(c + 1);
                end
                gacm_pkg::MODE_MULTI: begin
                    n       = len - 1;
                    k       = 32'(points_reg);
                    chosen  = 0;
                    swapped = 1'b0;
                    if (k < 1)
                        k = 1;
                    if (k > n)
                        k = n;
                    for (int t = 0; t < n; t++) begin
                        d = next_draw();
                        if (chosen < k && d * (n - t) < ((k - chosen) << 16)) begin
                            chosen++;
                            swapped = !swapped;
                        end
                        if (swapped)
                            sel[t + 1] = 1'b1;
                    end
                end
                gacm_pkg::MODE_UNIFORM: begin
                    for (int i = 0; i < len; i++)
                        if (!heads())
                            sel[i] = 1'b1;
                end
                default: ;
            endcase
        end
        if (r.error_code == gacm_pkg::ERR_OK) begin
            r.child_a = ((pa & ~sel) | (pb & sel)) & m;
            r.child_b = ((pb & ~sel) | (pa & sel)) & m;
        end
        return r;
    endfunction

    // receiver side
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
    end

    task automatic log_fault(input string what, input gacm_pkg::res_t want,
                             input gacm_pkg::res_t got);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t %s: expected a=%h b=%h err=%0d, got a=%h b=%h err=%0d", $realtime,
                     what, want.child_a, want.child_b, want.error_code,
                     got.child_a, got.child_b, got.error_code);
    endtask

    always @(posedge aclk) begin
        gacm_pkg::res_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_child_a, m_child_b, m_error_code};
            if (pending_children.size() == 0) begin
                log_fault("result item with none expected", '0, got);
            end else begin
                want = pending_children.pop_front();
                if (got.child_a !== want.child_a || got.child_b !== want.child_b ||
                    got.error_code !== want.error_code)
                    log_fault("result item mismatch", want, got);
            end
        end
    end

    initial begin : watchdog
        @(posedge aclk);
        while (stall_count < WATCHDOG_LIMIT)
            @(posedge aclk);
        $display("%0t no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
        $display("ga_crossover_mutation_engine test failed");
        $finish;
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            gacm_pkg::CFG_LENGTH: len_reg    = val[6:0];
            gacm_pkg::CFG_MODE:   mode_reg   = val[1:0];
            gacm_pkg::CFG_POINTS: points_reg = val[5:0];
            gacm_pkg::CFG_RATE:   rate_reg   = val[16:0];
            gacm_pkg::CFG_SEED:   xs_state   = (val == 0) ? 32'd1 : val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_item(input logic op, input logic [63:0] pa, input logic [63:0] pb,
                             input logic [63:0] qa, input logic [63:0] qb);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_operation <= op;
        s_parent_a  <= pa;
        s_parent_b  <= pb;
        s_protect_a <= qa;
        s_protect_b <= qb;
        s_valid     <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_children.push_back(breed_result(op, pa, pb, qa, qb));
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_children.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic random_item();
        logic [63:0] lm, pa, pb, qa, qb;
        int unsigned kind, eff, bit_pos;
        eff = active_length();
        lm  = low_mask(eff);
        pa  = rand64();
        pb  = rand64();
        qb  = rand64();
        case ($urandom_range(3))
            0: qa = '0;
            1: qa = rand64() & rand64() & rand64();
            2: qa = rand64();
            default: qa = ($urandom_range(7) == 0) ? '1 : rand64() & rand64();
        endcase
        kind = $urandom_range(99);
        if (kind < 30) begin
            send_item(gacm_pkg::OP_MUTATE, pa, pb, qa, qb);
        end else begin
            // well-formed pair, with junk above the length in the second mask, then at times a broken value or mask bit
            qb      = qa ^ (rand64() & ~lm);
            pa      = (pa & ~qa) | (pb & qa);
            bit_pos = $urandom_range(eff - 1);
            if (kind >= 94) begin
                qa[bit_pos] = 1'b1;
                qb[bit_pos] = 1'b1;
                pa[bit_pos] = ~pb[bit_pos];
            end else if (kind >= 88) begin
                qb[bit_pos] = ~qb[bit_pos];
            end
            send_item(gacm_pkg::OP_CROSS, pa, pb, qa, qb);
        end
    endtask

    task automatic pick_settings();
        int unsigned len_val, rate_val;
        case ($urandom_range(9))
            0, 1, 2, 3: len_val = 64;
            4: len_val = 1;
            5: len_val = 2;
            6: len_val = $urandom_range(1) ? 0 : $urandom_range(65, 127);
            default: len_val = $urandom_range(1, 64);
        endcase
        case ($urandom_range(5))
            0: rate_val = 0;
            1: rate_val = 65536;
            2: rate_val = $urandom_range(65537, 131071);
            3, 4: rate_val = $urandom_range(0, 4000);
            default: rate_val = $urandom_range(0, 65535);
        endcase
        write_reg(gacm_pkg::CFG_LENGTH, len_val);
        write_reg(gacm_pkg::CFG_MODE, $urandom_range(3));
        write_reg(gacm_pkg::CFG_POINTS,
                  $urandom_range(3) == 0 ? $urandom_range(63) : $urandom_range(1, 6));
        write_reg(gacm_pkg::CFG_RATE, rate_val);
        if ($urandom_range(2) == 0)
            write_reg(gacm_pkg::CFG_SEED, $urandom_range(3) == 0 ? 32'd0 : $urandom);
    endtask

    task automatic test_reset_values();
        send_item(gacm_pkg::OP_CROSS, '1, '0, '0, '0);
        send_item(gacm_pkg::OP_MUTATE, 64'hA5A5_5A5A_F00F_0FF0, '1, '0, '1);
    endtask

    task automatic test_protection_checks();
        logic [63:0] pb;
        pb = rand64();
        send_item(gacm_pkg::OP_CROSS, rand64(), pb, 64'h1, 64'h0);
        send_item(gacm_pkg::OP_CROSS, 64'h8000_0000_0000_0000, 64'h0,
                  64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001);
        send_item(gacm_pkg::OP_CROSS, pb, pb, '1, '1);
        send_item(gacm_pkg::OP_MUTATE, pb, '0, '1, '0);
    endtask

    task automatic test_crossover_modes();
        logic [63:0] pa, pb, qa;
        pa = rand64();
        pb = rand64();
        qa = 64'h0F00_0000_0000_00F0;
        pa = (pa & ~qa) | (pb & qa);
        wait_idle();
        write_reg(gacm_pkg::CFG_MODE, 32'(gacm_pkg::MODE_MULTI));
        write_reg(gacm_pkg::CFG_POINTS, 32'd0);
        send_item(gacm_pkg::OP_CROSS, pa, pb, qa, qa);
        wait_idle();
        write_reg(gacm_pkg::CFG_POINTS, 32'd63);
        send_item(gacm_pkg::OP_CROSS, '1, '0, '0, '0);
        wait_idle();
        write_reg(gacm_pkg::CFG_MODE, 32'(gacm_pkg::MODE_UNIFORM));
        send_item(gacm_pkg::OP_CROSS, '1, '0, '0, '0);
        send_item(gacm_pkg::OP_CROSS, pa, pb, qa, qa);
        wait_idle();
        write_reg(gacm_pkg::CFG_MODE, 32'd3);
        send_item(gacm_pkg::OP_CROSS, pa, pb, qa, qa);
    endtask

    task automatic test_length_limits();
        wait_idle();
        write_reg(gacm_pkg::CFG_MODE, 32'(gacm_pkg::MODE_SINGLE));
        write_reg(gacm_pkg::CFG_LENGTH, 32'd1);
        send_item(gacm_pkg::OP_CROSS, 64'h1, 64'h0, 64'h1, 64'h0);
        send_item(gacm_pkg::OP_CROSS, '1, 64'h2, '0, '1);
        wait_idle();
        write_reg(gacm_pkg::CFG_LENGTH, 32'd0);
        send_item(gacm_pkg::OP_CROSS, '0, '1, '0, '0);
        wait_idle();
        write_reg(gacm_pkg::CFG_LENGTH, 32'd127);
        send_item(gacm_pkg::OP_CROSS, '1, '0, '0, '0);
        send_item(gacm_pkg::OP_MUTATE, rand64(), '0, rand64(), '0);
        wait_idle();
        write_reg(gacm_pkg::CFG_LENGTH, 32'd2);
        send_item(gacm_pkg::OP_CROSS, '1, '0, '0, '0);
    endtask

    task automatic test_mutation_rates();
        wait_idle();
        write_reg(gacm_pkg::CFG_LENGTH, 32'd64);
        write_reg(gacm_pkg::CFG_RATE, 32'd0);
        send_item(gacm_pkg::OP_MUTATE, rand64(), '0, '0, '0);
        wait_idle();
        write_reg(gacm_pkg::CFG_RATE, 32'd65536);
        send_item(gacm_pkg::OP_MUTATE, '0, '0, 64'hFFFF_0000_0000_FFFF, '0);
        wait_idle();
        write_reg(gacm_pkg::CFG_RATE, 32'h1FFFF);
        send_item(gacm_pkg::OP_MUTATE, '1, '0, '0, '0);
    endtask

    task automatic test_seed_loading();
        wait_idle();
        write_reg(gacm_pkg::CFG_RATE, 32'd32768);
        write_reg(gacm_pkg::CFG_SEED, 32'd0);
        send_item(gacm_pkg::OP_MUTATE, '0, '0, '0, '0);
        wait_idle();
        write_reg(gacm_pkg::CFG_SEED, 32'hFFFF_FFFF);
        send_item(gacm_pkg::OP_MUTATE, '0, '0, '0, '0);
    endtask

    task automatic test_random_traffic();
        int idle_table[4][2] = '{'{0, 0}, '{55, 0}, '{0, 55}, '{26, 26}};
        for (int p = 0; p < 4; p++) begin
            for (int round = 0; round < 5; round++) begin
                wait_idle();
                src_idle_pct   = idle_table[p][0];
                sink_stall_pct = idle_table[p][1];
                pick_settings();
                repeat (65) random_item();
            end
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_operation    = gacm_pkg::OP_CROSS;
        s_parent_a     = '0;
        s_parent_b     = '0;
        s_protect_a    = '0;
        s_protect_b    = '0;
        m_ready        = 1'b0;
        fault_count    = 0;
        stall_count    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        len_reg        = 7'd64;
        mode_reg       = gacm_pkg::MODE_SINGLE;
        points_reg     = 6'd2;
        rate_reg       = 17'd655;
        xs_state       = 32'd1;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_values();
        test_protection_checks();
        test_crossover_modes();
        test_length_limits();
        test_mutation_rates();
        test_seed_loading();
        test_random_traffic();

        s_valid <= 1'b0;
        while (pending_children.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0)
            $display("ga_crossover_mutation_engine test passed");
        else
            $display("ga_crossover_mutation_engine test failed");
        $finish;
    end

endmodule
